FILE: design/depth_gated_color_segmenter_defines.svh
// ----------------------------------------------------------------------------
// Depth-gated colour segmenter: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_GATED_COLOR_SEGMENTER_DEFINES_SVH
`define DEPTH_GATED_COLOR_SEGMENTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGCS_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DGCS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/dgcs_pkg.sv
// ----------------------------------------------------------------------------
// Depth-gated colour segmenter package
// Payload types, register indexes, class codes and fill colours.
// ----------------------------------------------------------------------------
package dgcs_pkg;

   localparam int LINE_WIDTH_DEFAULT = 640;
   localparam int LINE_COUNT_DEFAULT = 480;

   localparam int POS_W   = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATS_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_A_LOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_A_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_B_LOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_B_HIGH = 3'd5;

   localparam logic [15:0] NEAR_LIMIT_RESET  = 16'd700;
   localparam logic [15:0] STATS_LIMIT_RESET = 16'd500;
   localparam logic [23:0] BOX_A_LOW_RESET   = 24'h003F84;
   localparam logic [23:0] BOX_A_HIGH_RESET  = 24'h64A3AF;
   localparam logic [23:0] BOX_B_LOW_RESET   = 24'h00BFBE;
   localparam logic [23:0] BOX_B_HIGH_RESET  = 24'h1414FF;

   localparam logic [1:0] CLASS_FAR     = 2'd0;
   localparam logic [1:0] CLASS_BOX_A   = 2'd1;
   localparam logic [1:0] CLASS_BOX_B   = 2'd2;
   localparam logic [1:0] CLASS_UNMATCH = 2'd3;

   localparam logic [31:0] FAR_FILL  = 32'hA0FFFFFF;
   localparam logic [31:0] MARK_FILL = 32'hFFFF00FF;
   localparam logic [31:0] MIN_CLEAR = 32'hFFFFFFFF;
   localparam logic [POS_W-1:0] SLOT_MAX = 19'h7FFFF;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic [15:0] depth_mm;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]       pixel_class;
      logic [31:0]      shown_color;
      logic [POS_W-1:0] pixel_position;
      logic [POS_W-1:0] class_slot;
      logic [31:0]      frame_min_color;
      logic [31:0]      frame_max_color;
      logic             stats_valid;
      logic             frame_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  pixel_class;
      logic [31:0] shown_color;
      logic        hit_a;
      logic        hit_b;
   } class_type;

endpackage

FILE: design/dgcs_classify.sv
// ----------------------------------------------------------------------------
// Depth-gated colour segmenter: pixel classifier
// Depth gate and two exclusive RGB box tests, giving class and shown colour.
// ----------------------------------------------------------------------------
module dgcs_classify (
   input  logic [31:0]         pixel_color,
   input  logic [15:0]         depth_mm,
   input  logic [15:0]         near_limit,
   input  logic [23:0]         box_a_low,
   input  logic [23:0]         box_a_high,
   input  logic [23:0]         box_b_low,
   input  logic [23:0]         box_b_high,
   output dgcs_pkg::class_type result
);
   import dgcs_pkg::*;

   function automatic logic in_box(logic [23:0] color, logic [23:0] lo, logic [23:0] hi);
      logic ok;
      ok = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
         if (!((lo[ch*8 +: 8] < color[ch*8 +: 8]) && (color[ch*8 +: 8] < hi[ch*8 +: 8]))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   logic is_near;
   logic match_a;
   logic match_b;

   assign is_near = depth_mm < near_limit;
   assign match_a = in_box(pixel_color[23:0], box_a_low, box_a_high);
   assign match_b = in_box(pixel_color[23:0], box_b_low, box_b_high);

   always_comb begin
      result.hit_a = 1'b0;
      result.hit_b = 1'b0;
      result.pixel_class = CLASS_FAR;
      result.shown_color = FAR_FILL;
      if (is_near) begin
         if (match_a) begin
            result.hit_a = 1'b1;
            result.pixel_class = CLASS_BOX_A;
            result.shown_color = pixel_color;
         end else if (match_b) begin
            result.hit_b = 1'b1;
            result.pixel_class = CLASS_BOX_B;
            result.shown_color = pixel_color;
         end else begin
            result.pixel_class = CLASS_UNMATCH;
            result.shown_color = MARK_FILL;
         end
      end
   end

endmodule

FILE: design/depth_gated_color_segmenter.sv
// ----------------------------------------------------------------------------
// Depth-gated colour segmenter
// Classifies pixels by depth and colour box, numbers object pixels per class
// and reports per-frame colour statistics on the last pixel of each frame.
//
//   Channel  Direction  Ports                                Content
//   req      in         req_valid, req_stall, req_payload    one pixel
//   rsp      out        rsp_valid, rsp_stall, rsp_payload    one result
//   csr      in         csr_write, csr_index, csr_data       register write
//
// A request enters the input register; its result moves into the output
// register once that register is empty or being taken, and is offered there.
// One request is accepted every cycle while the result side keeps taking.
// A stalled result holds the output register; the input register then fills
// and req_stall rises only when both are occupied.
// Reset is synchronous; it restores register defaults and clears all counters.
// ----------------------------------------------------------------------------
module depth_gated_color_segmenter #(
   parameter int LINE_WIDTH = dgcs_pkg::LINE_WIDTH_DEFAULT,
   parameter int LINE_COUNT = dgcs_pkg::LINE_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dgcs_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dgcs_pkg::rsp_type               rsp_payload,
   input  logic                            csr_write,
   input  logic [dgcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dgcs_pkg::CSR_DATA_W-1:0] csr_data
);
   import dgcs_pkg::*;

   `include "depth_gated_color_segmenter_defines.svh"

   localparam longint FRAME_SIZE = longint'(LINE_WIDTH) * longint'(LINE_COUNT);
   localparam logic [24:0] FRAME_SIZE_W = 25'(FRAME_SIZE);

   logic [15:0] near_limit_ff;
   logic [15:0] stats_limit_ff;
   logic [23:0] box_a_low_ff;
   logic [23:0] box_a_high_ff;
   logic [23:0] box_b_low_ff;
   logic [23:0] box_b_high_ff;

   logic        in_valid_ff;
   req_type     in_req_ff;
   logic        out_valid_ff;
   rsp_type     out_rsp_ff;
   rsp_type     out_rsp_in;

   logic [POS_W-1:0] position_ff;
   logic [POS_W-1:0] position_in;
   logic [POS_W-1:0] count_a_ff;
   logic [POS_W-1:0] count_a_in;
   logic [POS_W-1:0] count_b_ff;
   logic [POS_W-1:0] count_b_in;
   logic [31:0]      run_min_ff;
   logic [31:0]      run_min_in;
   logic [31:0]      run_max_ff;
   logic [31:0]      run_max_in;

   logic        advance;
   class_type   cls;
   logic        qualify;
   logic [31:0] new_min;
   logic [31:0] new_max;
   logic        have_stats;
   logic [POS_W:0] pos_inc;

   logic        out_stats;
   logic        out_plain;
   logic        stats_zero;
   logic        out_slotted;
   logic        object_class;
   logic        frame_done;
   logic        frame_cleared;
   logic        pipe_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_limit_ff  <= NEAR_LIMIT_RESET;
         stats_limit_ff <= STATS_LIMIT_RESET;
         box_a_low_ff   <= BOX_A_LOW_RESET;
         box_a_high_ff  <= BOX_A_HIGH_RESET;
         box_b_low_ff   <= BOX_B_LOW_RESET;
         box_b_high_ff  <= BOX_B_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NEAR_LIMIT:  near_limit_ff  <= csr_data[15:0];
            CSR_STATS_LIMIT: stats_limit_ff <= csr_data[15:0];
            CSR_BOX_A_LOW:   box_a_low_ff   <= csr_data;
            CSR_BOX_A_HIGH:  box_a_high_ff  <= csr_data;
            CSR_BOX_B_LOW:   box_b_low_ff   <= csr_data;
            CSR_BOX_B_HIGH:  box_b_high_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_req_ff <= req_payload;
      end
   end

   dgcs_classify u_classify (
      .pixel_color (in_req_ff.pixel_color),
      .depth_mm    (in_req_ff.depth_mm),
      .near_limit  (near_limit_ff),
      .box_a_low   (box_a_low_ff),
      .box_a_high  (box_a_high_ff),
      .box_b_low   (box_b_low_ff),
      .box_b_high  (box_b_high_ff),
      .result      (cls)
   );

   assign qualify = (in_req_ff.depth_mm < stats_limit_ff) && (cls.shown_color != MARK_FILL)
                    && (cls.shown_color != 32'd0);
   assign new_min = (qualify && (cls.shown_color < run_min_ff)) ? cls.shown_color : run_min_ff;
   assign new_max = (qualify && (cls.shown_color > run_max_ff)) ? cls.shown_color : run_max_ff;
   assign have_stats = !((new_min == MIN_CLEAR) && (new_max == 32'd0));
   assign pos_inc = {1'b0, position_ff} + {{POS_W{1'b0}}, 1'b1};

   always_comb begin
      out_rsp_in.pixel_class    = cls.pixel_class;
      out_rsp_in.shown_color    = cls.shown_color;
      out_rsp_in.pixel_position = position_ff;
      out_rsp_in.class_slot     = cls.hit_a ? count_a_ff : (cls.hit_b ? count_b_ff : '0);
      out_rsp_in.frame_last     = in_req_ff.frame_end;
      out_rsp_in.stats_valid    = in_req_ff.frame_end && have_stats;
      out_rsp_in.frame_min_color = out_rsp_in.stats_valid ? new_min : 32'd0;
      out_rsp_in.frame_max_color = out_rsp_in.stats_valid ? new_max : 32'd0;

      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (cls.hit_a && (count_a_ff != SLOT_MAX)) begin
         count_a_in = count_a_ff + 1'b1;
      end
      if (cls.hit_b && (count_b_ff != SLOT_MAX)) begin
         count_b_in = count_b_ff + 1'b1;
      end
      if (25'(pos_inc) >= FRAME_SIZE_W) begin
         position_in = '0;
      end else begin
         position_in = pos_inc[POS_W-1:0];
      end
      run_min_in = new_min;
      run_max_in = new_max;
      if (in_req_ff.frame_end) begin
         position_in = '0;
         count_a_in  = '0;
         count_b_in  = '0;
         run_min_in  = MIN_CLEAR;
         run_max_in  = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         run_min_ff  <= MIN_CLEAR;
         run_max_ff  <= 32'd0;
      end else if (advance) begin
         position_ff <= position_in;
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         run_min_ff  <= run_min_in;
         run_max_ff  <= run_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

   assign out_stats    = out_valid_ff && out_rsp_ff.stats_valid;
   assign out_plain    = out_valid_ff && !out_rsp_ff.stats_valid;
   assign stats_zero   = (out_rsp_ff.frame_min_color == 32'd0)
                         && (out_rsp_ff.frame_max_color == 32'd0);
   assign out_slotted  = out_valid_ff && (out_rsp_ff.class_slot != '0);
   assign object_class = (out_rsp_ff.pixel_class == CLASS_BOX_A)
                         || (out_rsp_ff.pixel_class == CLASS_BOX_B);
   assign frame_done   = advance && in_req_ff.frame_end;
   assign frame_cleared = (position_ff == '0) && (count_a_ff == '0) && (count_b_ff == '0)
                          && (run_min_ff == MIN_CLEAR) && (run_max_ff == 32'd0);
   assign pipe_full    = in_valid_ff && out_valid_ff && rsp_stall;

   `DGCS_ASSERT_SAME(a_stats_on_last, out_stats, out_rsp_ff.frame_last, "Statistics off the last pixel.")
   `DGCS_ASSERT_SAME(a_stats_zero, out_plain, stats_zero, "Statistics without the valid flag.")
   `DGCS_ASSERT_SAME(a_slot_class, out_slotted, object_class, "Slot outside the object classes.")
   `DGCS_ASSERT_NEXT(a_frame_clear, frame_done, frame_cleared, "Frame state not cleared.")
   `DGCS_ASSERT_SAME(a_stall_full, req_stall, pipe_full, "Request stalled with room to spare.")

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Depth-gated colour segmenter testbench
// Drives pixel requests with random idling on both channels and predicts each
// result in a scoreboard that mirrors the class counters, raster position and
// frame colour statistics. Covers directed corner cases and randomly
// configured phases.
// ----------------------------------------------------------------------------
module tb;
   import dgcs_pkg::*;

   localparam int FRAME_PIXELS = LINE_WIDTH_DEFAULT * LINE_COUNT_DEFAULT;
   localparam int QUIET_LIMIT = 1000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_PIXELS = 325;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   class pixel_scoreboard;
      logic [15:0]      near_limit;
      logic [15:0]      stats_limit;
      logic [23:0]      box_a_low;
      logic [23:0]      box_a_high;
      logic [23:0]      box_b_low;
      logic [23:0]      box_b_high;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] slots_a;
      logic [POS_W-1:0] slots_b;
      logic [31:0]      frame_min;
      logic [31:0]      frame_max;
      rsp_type          predicted_pixels[$];
      int               fault_count;
      int               checked;

      function new();
         near_limit  = NEAR_LIMIT_RESET;
         stats_limit = STATS_LIMIT_RESET;
         box_a_low   = BOX_A_LOW_RESET;
         box_a_high  = BOX_A_HIGH_RESET;
         box_b_low   = BOX_B_LOW_RESET;
         box_b_high  = BOX_B_HIGH_RESET;
         fault_count = 0;
         checked     = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         position  = '0;
         slots_a   = '0;
         slots_b   = '0;
         frame_min = MIN_CLEAR;
         frame_max = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_NEAR_LIMIT: near_limit = data[15:0];
            CSR_STATS_LIMIT: stats_limit = data[15:0];
            CSR_BOX_A_LOW: box_a_low = data;
            CSR_BOX_A_HIGH: box_a_high = data;
            CSR_BOX_B_LOW: box_b_low = data;
            CSR_BOX_B_HIGH: box_b_high = data;
            default: ;
         endcase
      endfunction

      function bit in_box(logic [31:0] color, logic [23:0] low, logic [23:0] high);
         for (int ch = 0; ch < 3; ch++) begin
            if (!(low[8*ch +: 8] < color[8*ch +: 8] && color[8*ch +: 8] < high[8*ch +: 8]))
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_pixel(req_type pixel);
         rsp_type r;
         r = '0;
         r.pixel_class    = CLASS_FAR;
         r.shown_color    = FAR_FILL;
         r.pixel_position = position;
         r.frame_last     = pixel.frame_end;
         if (pixel.depth_mm < near_limit) begin
            if (in_box(pixel.pixel_color, box_a_low, box_a_high)) begin
               r.pixel_class = CLASS_BOX_A;
               r.shown_color = pixel.pixel_color;
               r.class_slot  = slots_a;
               if (slots_a != SLOT_MAX) slots_a++;
            end else if (in_box(pixel.pixel_color, box_b_low, box_b_high)) begin
               r.pixel_class = CLASS_BOX_B;
               r.shown_color = pixel.pixel_color;
               r.class_slot  = slots_b;
               if (slots_b != SLOT_MAX) slots_b++;
            end else begin
               r.pixel_class = CLASS_UNMATCH;
               r.shown_color = MARK_FILL;
            end
         end
         if (pixel.depth_mm < stats_limit && r.shown_color != MARK_FILL && r.shown_color != 0) begin
            if (r.shown_color < frame_min) frame_min = r.shown_color;
            if (r.shown_color > frame_max) frame_max = r.shown_color;
         end
         if (int'(position) + 1 >= FRAME_PIXELS) position = '0;
         else position++;
         if (pixel.frame_end) begin
            if (!(frame_min == MIN_CLEAR && frame_max == 0)) begin
               r.stats_valid     = 1'b1;
               r.frame_min_color = frame_min;
               r.frame_max_color = frame_max;
            end
            restart_frame();
         end
         predicted_pixels = {predicted_pixels, r};
      endfunction

      function string field_note(string name, logic [31:0] want, logic [31:0] got);
         if (got === want) return "";
         return $sformatf(" %s expected %h got %h", name, want, got);
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         string   diffs;
         if (predicted_pixels.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("Result %h arrived with no request outstanding.", got);
            return;
         end
         want = predicted_pixels.pop_front();
         diffs = {field_note("class", want.pixel_class, got.pixel_class),
                  field_note("colour", want.shown_color, got.shown_color),
                  field_note("position", want.pixel_position, got.pixel_position),
                  field_note("slot", want.class_slot, got.class_slot),
                  field_note("min", want.frame_min_color, got.frame_min_color),
                  field_note("max", want.frame_max_color, got.frame_max_color),
                  field_note("stats_valid", want.stats_valid, got.stats_valid),
                  field_note("last", want.frame_last, got.frame_last)};
         if (diffs != "") begin
            fault_count++;
            if (fault_count <= 10) $display("Result %0d mismatch:%s", checked, diffs);
         end
         checked++;
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   bit                    no_idle = 1'b0;
   int                    quiet_cycles = 0;
   pixel_scoreboard       sb = new();

   depth_gated_color_segmenter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_pixel(req_payload);
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_payload);
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("depth_gated_color_segmenter verification failed");
         $finish;
      end
   end

   task automatic send_pixel(logic [31:0] color, logic [15:0] depth, bit last);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{pixel_color: color, depth_mm: depth, frame_end: last};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.predicted_pixels.size() != 0) @(negedge clock);
   endtask

   // Leaves csr_write high; the caller lowers it after the last write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 2000));
      endcase
   endfunction

   function automatic logic [47:0] pick_box();
      logic [23:0] low;
      logic [23:0] high;
      int          pick;
      for (int ch = 0; ch < 3; ch++) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            low[8*ch +: 8]  = 8'h00;
            high[8*ch +: 8] = 8'hFF;
         end else if (pick == 1) begin
            low[8*ch +: 8]  = 8'hFF;
            high[8*ch +: 8] = 8'h00;
         end else if (pick == 2) begin
            low[8*ch +: 8]  = 8'($urandom);
            high[8*ch +: 8] = 8'($urandom);
         end else begin
            low[8*ch +: 8]  = 8'($urandom_range(0, 200));
            high[8*ch +: 8] = low[8*ch +: 8] + 8'($urandom_range(2, 55));
         end
      end
      return {low, high};
   endfunction

   task automatic choose_settings();
      logic [47:0] box;
      write_reg(CSR_NEAR_LIMIT, {8'($urandom), pick_limit()});
      write_reg(CSR_STATS_LIMIT, {8'($urandom), pick_limit()});
      box = pick_box();
      write_reg(CSR_BOX_A_LOW, box[47:24]);
      write_reg(CSR_BOX_A_HIGH, box[23:0]);
      box = pick_box();
      write_reg(CSR_BOX_B_LOW, box[47:24]);
      write_reg(CSR_BOX_B_HIGH, box[23:0]);
      if ($urandom_range(1) == 0) write_reg(CSR_SPARE_LO, 24'($urandom));
      else write_reg(CSR_SPARE_HI, 24'($urandom));
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] pick_color();
      logic [23:0] low;
      logic [23:0] high;
      logic [23:0] rgb;
      logic [7:0]  bound;
      int          mode;
      mode = $urandom_range(9);
      low  = (mode < 4) ? sb.box_a_low : sb.box_b_low;
      high = (mode < 4) ? sb.box_a_high : sb.box_b_high;
      for (int ch = 0; ch < 3; ch++) begin
         if (mode < 6 && int'(high[8*ch +: 8]) > int'(low[8*ch +: 8]) + 1) begin
            rgb[8*ch +: 8] = 8'($urandom_range(int'(high[8*ch +: 8]) - 1,
                                               int'(low[8*ch +: 8]) + 1));
         end else if (mode == 6) begin
            case ($urandom_range(3))
               0: bound = sb.box_a_low[8*ch +: 8];
               1: bound = sb.box_a_high[8*ch +: 8];
               2: bound = sb.box_b_low[8*ch +: 8];
               default: bound = sb.box_b_high[8*ch +: 8];
            endcase
            rgb[8*ch +: 8] = bound + 8'($urandom_range(0, 2)) - 8'd1;
         end else begin
            rgb[8*ch +: 8] = 8'($urandom);
         end
      end
      return {8'($urandom), rgb};
   endfunction

   function automatic logic [15:0] pick_depth();
      int d;
      case ($urandom_range(7))
         0: d = 0;
         1: d = 65535;
         2: d = int'(sb.near_limit) + int'($urandom_range(0, 4)) - 2;
         3: d = int'(sb.stats_limit) + int'($urandom_range(0, 4)) - 2;
         4, 5: d = int'($urandom_range(0, sb.near_limit));
         6: d = int'($urandom_range(0, 65535));
         default: d = int'($urandom_range(0, 1500));
      endcase
      if (d < 0) d = 0;
      if (d > 65535) d = 65535;
      return 16'(d);
   endfunction

   initial begin
      int end_odds;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Default settings: box A edges, alpha, zero depth, stats boundary.
      send_pixel(32'hFF307090, 16'd0, 1'b0);
      send_pixel(32'h00307090, 16'd499, 1'b0);
      send_pixel(32'h00000000, 16'd699, 1'b0);
      send_pixel(32'hFF64A3AF, 16'd500, 1'b0);
      send_pixel(32'hFF003F84, 16'd1, 1'b0);
      send_pixel(32'hFF014085, 16'd698, 1'b0);
      send_pixel(32'hFF63A2AE, 16'd500, 1'b0);
      send_pixel(32'hFFFFFFFF, 16'd700, 1'b0);
      send_pixel(32'h00000000, 16'hFFFF, 1'b1);
      send_pixel(32'hFF307090, 16'd600, 1'b1);

      // Overlapping boxes, stats window wider than the near window.
      drain();
      write_reg(CSR_NEAR_LIMIT, 24'hAB0064);
      write_reg(CSR_STATS_LIMIT, 24'h00FFFF);
      write_reg(CSR_BOX_A_LOW, 24'h101010);
      write_reg(CSR_BOX_A_HIGH, 24'h404040);
      write_reg(CSR_BOX_B_LOW, 24'h000000);
      write_reg(CSR_BOX_B_HIGH, 24'hFFFFFF);
      write_reg(CSR_SPARE_LO, 24'h000000);
      write_reg(CSR_SPARE_HI, 24'hFFFFFF);
      csr_write <= 1'b0;
      send_pixel(32'hFF202020, 16'd50, 1'b0);
      send_pixel(32'h12808080, 16'd99, 1'b0);
      send_pixel(32'hFFFF0000, 16'd20, 1'b0);
      send_pixel(32'hFF000001, 16'd100, 1'b0);
      send_pixel(32'h00FEFEFE, 16'd0, 1'b0);
      send_pixel(32'hFF202020, 16'hFFFF, 1'b1);

      // Empty windows and empty boxes.
      drain();
      write_reg(CSR_NEAR_LIMIT, 24'hFF0000);
      write_reg(CSR_STATS_LIMIT, 24'h000000);
      write_reg(CSR_BOX_A_LOW, 24'hFFFFFF);
      write_reg(CSR_BOX_A_HIGH, 24'h000000);
      write_reg(CSR_BOX_B_LOW, 24'hFFFFFF);
      write_reg(CSR_BOX_B_HIGH, 24'h000000);
      csr_write <= 1'b0;
      send_pixel(32'hFF202020, 16'd0, 1'b0);
      send_pixel(32'h5A5A5A5A, 16'd0, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         choose_settings();
         no_idle  = (phase == 2);
         end_odds = $urandom_range(2, 60);
         repeat (PHASE_PIXELS) begin
            send_pixel(pick_color(), pick_depth(), $urandom_range(end_odds - 1) == 0);
         end
      end
      no_idle = 1'b0;

      drain();
      repeat (4) @(negedge clock);
      if (sb.fault_count == 0 && sb.predicted_pixels.size() == 0) begin
         $display("depth_gated_color_segmenter verification clean");
      end else begin
         $display("depth_gated_color_segmenter verification failed");
      end
      $finish;
   end
endmodule
